// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/cbsh_pkg.sv -----
package cbsh_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_ABSORB        = 2'd0;
  localparam logic [1:0] CMD_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] CMD_FINISH        = 2'd2;

  localparam logic [15:0] MIX_NUMERATOR = 16'd46886;
  localparam logic [31:0] COUNTER_START = 32'd7;
  localparam logic [3:0]  COUNTER_START_MOD10 = 4'd7;
  localparam logic [3:0]  MOD10_LAST = 4'd9;
  localparam logic [27:0] MAX_BYTES = 28'hFFFFFFF;
  localparam logic [31:0] MIX_ADD = 32'h85ebca6b;
  localparam logic [31:0] MIX_XOR = 32'hc2b2ae35;

  localparam logic [2:0] LAST_WORD = 3'd7;
  localparam logic [3:0] LAST_LEN_BYTE = 4'd15;
  // The divider retires four quotient bits per cycle.
  localparam logic [1:0] DIV_LAST_STEP = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MIX,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       absorb;    // capture data_byte and count it
    logic       load_len;  // capture one length byte
    logic [2:0] len_sel;   // which length byte, most significant first
    logic       div_en;    // run one divider step
    logic [1:0] div_step;  // divider step number
    logic       mix;       // update the selected hash word
    logic       clear;     // return the hash state to its reset values
    logic [2:0] widx;      // selected hash word
  } ctl_t;

endpackage

// ----- design/cbsh_ctrl.sv -----
module cbsh_ctrl
  import cbsh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] word_index,
  output logic       last_word,
  output ctl_t       ctl
);

  state_t     state, state_next;
  logic [2:0] widx, widx_next;
  logic [1:0] step, step_next;
  logic [3:0] len_cnt, len_cnt_next;
  logic       pend_finish, pend_finish_next;
  logic       finishing, finishing_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      widx        <= '0;
      step        <= '0;
      len_cnt     <= '0;
      pend_finish <= 1'b0;
      finishing   <= 1'b0;
    end else begin
      state       <= state_next;
      widx        <= widx_next;
      step        <= step_next;
      len_cnt     <= len_cnt_next;
      pend_finish <= pend_finish_next;
      finishing   <= finishing_next;
    end
  end

  always_comb begin
    state_next       = state;
    widx_next        = widx;
    step_next        = step;
    len_cnt_next     = len_cnt;
    pend_finish_next = pend_finish;
    finishing_next   = finishing;
    in_stall         = 1'b1;
    out_valid        = 1'b0;
    ctl              = '0;
    ctl.widx         = widx;
    ctl.div_step     = step;
    ctl.len_sel      = len_cnt[2:0];
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (cmd)
            CMD_ABSORB, CMD_ABSORB_FINISH: begin
              ctl.absorb       = 1'b1;
              pend_finish_next = (cmd == CMD_ABSORB_FINISH);
              finishing_next   = 1'b0;
              widx_next        = '0;
              step_next        = '0;
              state_next       = ST_DIV;
            end
            CMD_FINISH: begin
              ctl.load_len     = 1'b1;
              ctl.len_sel      = '0;
              len_cnt_next     = '0;
              pend_finish_next = 1'b0;
              finishing_next   = 1'b1;
              widx_next        = '0;
              step_next        = '0;
              state_next       = ST_DIV;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        ctl.div_en = 1'b1;
        if (step == DIV_LAST_STEP) begin
          step_next  = '0;
          state_next = ST_MIX;
        end else begin
          step_next = step + 2'd1;
        end
      end
      ST_MIX: begin
        ctl.mix = 1'b1;
        if (widx == LAST_WORD) begin
          widx_next = '0;
          if (finishing) begin
            if (len_cnt == LAST_LEN_BYTE) begin
              state_next = ST_EMIT;
            end else begin
              len_cnt_next = len_cnt + 4'd1;
              ctl.load_len = 1'b1;
              ctl.len_sel  = len_cnt_next[2:0];
              state_next   = ST_DIV;
            end
          end else if (pend_finish) begin
            pend_finish_next = 1'b0;
            finishing_next   = 1'b1;
            len_cnt_next     = '0;
            ctl.load_len     = 1'b1;
            ctl.len_sel      = '0;
            state_next       = ST_DIV;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          widx_next  = widx + 3'd1;
          state_next = ST_DIV;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (widx == LAST_WORD) begin
            ctl.clear      = 1'b1;
            widx_next      = '0;
            finishing_next = 1'b0;
            state_next     = ST_IDLE;
          end else begin
            widx_next = widx + 3'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign word_index = widx;
  assign last_word  = (widx == LAST_WORD);

endmodule

// ----- design/cbsh_datapath.sv -----
module cbsh_datapath
  import cbsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  input  logic [7:0]  data_byte,
  output logic [31:0] digest_word,
  output logic        too_long
);

  logic [31:0] hash_words [8];
  logic [31:0] mix_counter;
  logic [3:0]  counter_mod10;
  logic [27:0] byte_count;
  logic        overflow_flag;
  logic [7:0]  cur_byte;
  logic [15:0] rem, rem_next;
  logic [15:0] quot, quot_next;

  logic [7:0]  len_byte;
  logic [31:0] mixed;

  // Length bytes: the bit count is below 2^31, so the upper four bytes are zero.
  always_comb begin
    logic [31:0] bits;
    bits = {1'b0, byte_count, 3'b000};
    case (ctl.len_sel)
      3'd4:    len_byte = bits[31:24];
      3'd5:    len_byte = bits[23:16];
      3'd6:    len_byte = bits[15:8];
      3'd7:    len_byte = bits[7:0];
      default: len_byte = 8'h00;
    endcase
  end

  // Restoring divider, four quotient bits per step, most significant first.
  always_comb begin
    logic [16:0] trial;
    logic [15:0] r;
    logic [3:0]  nib;
    logic [3:0]  shamt;
    shamt = 4'd12 - {ctl.div_step, 2'b00};
    nib   = 4'(MIX_NUMERATOR >> shamt);
    r     = (ctl.div_step == 2'd0) ? 16'd0 : rem;
    quot_next = {quot[11:0], 4'b0000};
    for (int b = 3; b >= 0; b--) begin
      trial = {r, nib[b]};
      if (trial >= {1'b0, mix_counter[15:0]}) begin
        trial = trial - {1'b0, mix_counter[15:0]};
        quot_next[b] = 1'b1;
      end
      r = trial[15:0];
    end
    rem_next = r;
  end

  // One word update.
  always_comb begin
    logic [31:0] q;
    logic [31:0] term;
    logic [31:0] prod;
    logic [31:0] ext;
    logic [31:0] w1;
    logic [31:0] w2;
    q = ((mix_counter[31:16] == 16'd0) && (mix_counter[15:0] != 16'd0))
        ? {16'd0, quot} : 32'd0;
    term  = q - {28'd0, counter_mod10};
    prod  = 32'(term * {28'd0, {1'b0, ctl.widx} + 4'd1});
    ext   = {{24{cur_byte[7]}}, cur_byte};
    w1    = (hash_words[ctl.widx] ^ ext) + prod;
    w2    = w1 ^ ({w1[16:0], 15'd0} | {21'd0, w1[31:21]});
    mixed = (w2 + MIX_ADD) ^ MIX_XOR;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < 8; i++) begin
        hash_words[i] <= '0;
      end
      mix_counter   <= COUNTER_START;
      counter_mod10 <= COUNTER_START_MOD10;
      byte_count    <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (ctl.absorb) begin
        if (byte_count == MAX_BYTES) begin
          overflow_flag <= 1'b1;
        end else begin
          byte_count <= byte_count + 28'd1;
        end
      end
      if (ctl.mix) begin
        hash_words[ctl.widx] <= mixed;
        mix_counter <= mix_counter + 32'd1;
        // 2^32 is not a multiple of ten, so the residue restarts on wrap.
        if (mix_counter == 32'hFFFFFFFF || counter_mod10 == MOD10_LAST) begin
          counter_mod10 <= '0;
        end else begin
          counter_mod10 <= counter_mod10 + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.absorb) begin
      cur_byte <= data_byte;
    end else if (ctl.load_len) begin
      cur_byte <= len_byte;
    end
    if (ctl.div_en) begin
      rem  <= rem_next;
      quot <= quot_next;
    end
  end

  assign digest_word = hash_words[ctl.widx];
  assign too_long    = overflow_flag;

endmodule

// ----- design/custom_byte_stream_hash.sv -----
// A byte is taken only while idle and then runs eight word updates before the next is taken.
// Finish adds sixteen length bytes, then eight digest words one per cycle while out_stall is low.
// Each word update waits on the shared divider, which forms 46886/counter.
// Synchronous reset clears the hash words, the byte count and the overflow flag
// and sets the mix counter to 7; the same state returns after the last word.
module custom_byte_stream_hash
  import cbsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        too_long
);

  // The controller sequences every byte as eight word updates. Each update runs
  // the divider in ST_DIV and then writes the word in ST_MIX.
  // Input transactions are taken only while the controller is idle.
  ctl_t ctl;

  cbsh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (word_index),
    .last_word  (last_word),
    .ctl        (ctl)
  );

  // The datapath holds the hash words, the mix counter with its residue modulo
  // ten, the byte count and the divider. While digest words are shown, the
  // selected hash word drives the output and holds steady under stall.
  cbsh_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .data_byte   (data_byte),
    .digest_word (digest_word),
    .too_long    (too_long)
  );

endmodule

// ----- design/cbsh_checker.sv -----
`include "assert_macros.svh"

module cbsh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word,
  input logic        too_long
);

  // Index and overflow flag of the current word, and what the next word of
  // the same digest must show.
  logic [3:0] out_tag;
  logic [3:0] next_tag;
  logic       emit_step;
  assign out_tag   = {word_index, too_long};
  assign next_tag  = {word_index + 3'd1, too_long};
  assign emit_step = out_valid && !out_stall && !last_word;

  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(digest_word))
  `CHK_SAME(a_no_input_while_emit, clk, rst, out_valid, in_stall)
  `CHK_SAME(a_last_flag, clk, rst, out_valid, last_word == (word_index == 3'd7))
  `CHK_NEXT(a_index_steps, clk, rst, emit_step, out_valid && out_tag == $past(next_tag))
  `CHK_NEXT(a_ends_after_last, clk, rst, out_valid && !out_stall && last_word, !out_valid)

endmodule

bind custom_byte_stream_hash cbsh_checker u_cbsh_checker (.*);

// ----- sim/custom_byte_stream_hash_tb.sv -----
`timescale 1ns / 1ps

module custom_byte_stream_hash_tb;
  import cbsh_pkg::*;

  // The package names the three live commands. Code 3 is reserved and the
  // block must swallow it without touching its state.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_WORDS = 8;

  // One digest word as it should leave the block.
  typedef struct {
    bit [31:0] word;
    bit [2:0]  index;
    bit        last;
    bit        long_msg;
  } digest_word_t;

  // Scoreboard: keeps its own copy of the hash state, mirrors every accepted
  // input transaction into it and queues the eight words that a finish emits.
  // Output transactions are checked against the head of that queue.
  class digest_scoreboard;
    bit [31:0]    hash_w[NUM_WORDS];
    bit [31:0]    mix_ctr;
    bit [28:0]    msg_bytes;
    bit           long_flag;
    digest_word_t pending[$];
    int           errors;
    int           words_checked;
    int           messages;
    int           bytes_absorbed;
    int           ignored;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      foreach (hash_w[i]) hash_w[i] = '0;
      mix_ctr   = COUNTER_START;
      msg_bytes = '0;
      long_flag = 1'b0;
    endfunction

    // Eight word updates for one byte; the counter advances once per word.
    function void mix_byte(bit [7:0] b);
      bit [31:0] ext;
      bit [31:0] quot;
      bit [31:0] term;
      bit [31:0] w;
      ext = {{24{b[7]}}, b};
      for (int i = 0; i < NUM_WORDS; i++) begin
        quot = (mix_ctr != 0) ? 32'(MIX_NUMERATOR) / mix_ctr : 32'd0;
        term = quot - (mix_ctr % 32'd10);
        w = (hash_w[i] ^ ext) + term * 32'(i + 1);
        w = w ^ ((w << 15) | (w >> 21));
        w = (w + MIX_ADD) ^ MIX_XOR;
        hash_w[i] = w;
        mix_ctr = mix_ctr + 32'd1;
      end
    endfunction

    function void absorb_byte(bit [7:0] b);
      if (msg_bytes >= 29'(MAX_BYTES)) begin
        long_flag = 1'b1;
        msg_bytes = 29'(MAX_BYTES);
      end else begin
        msg_bytes = msg_bytes + 29'd1;
      end
      mix_byte(b);
      bytes_absorbed++;
    endfunction

    // The bit length goes in twice, most significant byte first, then the
    // words are queued and the state goes back to its reset values.
    function void finish_message();
      bit [63:0]    len_bits;
      digest_word_t d;
      len_bits = {35'd0, msg_bytes} << 3;
      repeat (2) begin
        for (int k = 7; k >= 0; k--) mix_byte(len_bits[k*8 +: 8]);
      end
      for (int i = 0; i < NUM_WORDS; i++) begin
        d.word     = hash_w[i];
        d.index    = 3'(i);
        d.last     = (3'(i) == LAST_WORD);
        d.long_msg = long_flag;
        pending.push_back(d);
      end
      messages++;
      clear_state();
    endfunction

    function void note_input(bit [1:0] c, bit [7:0] b);
      case (c)
        CMD_ABSORB: absorb_byte(b);
        CMD_ABSORB_FINISH: begin
          absorb_byte(b);
          finish_message();
        end
        CMD_FINISH: finish_message();
        default: ignored++;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(bit [31:0] word, bit [2:0] index, bit last, bit long_msg);
      digest_word_t d;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %08h index %0d", word, index));
      end else begin
        d = pending.pop_front();
        words_checked++;
        if (word !== d.word)
          report_mismatch($sformatf("digest_word %08h, wanted %08h (index %0d)",
                                    word, d.word, d.index));
        if (index !== d.index)
          report_mismatch($sformatf("word_index %0d, wanted %0d", index, d.index));
        if (last !== d.last)
          report_mismatch($sformatf("last_word %0b, wanted %0b (index %0d)",
                                    last, d.last, d.index));
        if (long_msg !== d.long_msg)
          report_mismatch($sformatf("too_long %0b, wanted %0b", long_msg, d.long_msg));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        too_long;

  // Idle and stall rates in percent, changed from phase to phase by the
  // stimulus process; the sender reads the idle rate, the receiver the stall rate.
  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent = 0;

  digest_scoreboard sb;

  custom_byte_stream_hash dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digest_word(digest_word),
    .word_index (word_index),
    .last_word  (last_word),
    .too_long   (too_long)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Offers one input transaction. Idle cycles come first, with junk on the
  // payload while valid is low; once valid rises the payload holds until the
  // block takes it. Handshake signals are sampled right after the edge, so
  // they still carry the values that the block saw at that edge.
  task send_item(input logic [1:0] c, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid  <= 1'b0;
      cmd       <= 2'($urandom);
      data_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(c, b);
    if (c != CMD_UNUSED) items_sent++;
  endtask

  // Byte values lean on the sign boundary and the all-zero and all-one
  // patterns, since sign extension is where the mixing can go wrong.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One whole message: mostly a handful of bytes, now and then a longer one,
  // sometimes none at all. The reserved command is sprinkled in as noise.
  // The message ends either on a final byte or on a bare finish.
  task send_message();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
    for (int j = 0; j < len; j++) begin
      if ($urandom_range(11) == 0) send_item(CMD_UNUSED, 8'($urandom));
      send_item(CMD_ABSORB, pick_byte());
    end
    if ($urandom_range(1) == 0) send_item(CMD_ABSORB_FINISH, pick_byte());
    else send_item(CMD_FINISH, 8'($urandom));
  endtask

  // Output side: a result transaction is checked at the edge where it is
  // taken, and the stall for the next cycle is drawn afterward.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(digest_word, word_index, last_word, too_long);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Main stimulus.
  initial begin
    sb = new;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with no idling on either side. It opens with an empty
    // message, then another one to show that the state came back clean, then
    // one-byte messages at the extremes of the byte range, a message with the
    // reserved command in its middle, reserved commands on their own and two more messages.
    send_item(CMD_FINISH, 8'hA5);
    send_item(CMD_FINISH, 8'h00);
    send_item(CMD_ABSORB_FINISH, 8'h00);
    send_item(CMD_ABSORB_FINISH, 8'hFF);
    send_item(CMD_ABSORB_FINISH, 8'h80);
    send_item(CMD_ABSORB, 8'h80);
    send_item(CMD_UNUSED, 8'h5A);
    send_item(CMD_ABSORB, 8'h7F);
    send_item(CMD_FINISH, 8'hFF);
    send_item(CMD_UNUSED, 8'hFF);
    send_item(CMD_UNUSED, 8'h00);
    send_item(CMD_ABSORB, 8'h01);
    send_item(CMD_ABSORB, 8'hFE);
    send_item(CMD_ABSORB, 8'h55);
    send_item(CMD_ABSORB_FINISH, 8'hAA);
    send_item(CMD_ABSORB, 8'hFF);
    send_item(CMD_ABSORB, 8'hFF);
    send_item(CMD_ABSORB_FINISH, 8'h7F);

    // Random part in four phases: no idling, a sluggish sender, a sluggish
    // receiver, then both sides pausing now and then.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      while (items_sent < 18 + 40 * (phase + 1)) send_message();
    end
    in_valid <= 1'b0;

    // Drain: every queued word has to come out, then a quiet stretch at least as
    // long as one finish takes shows that nothing extra follows.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (720) @(posedge clk);

    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d digest words never arrived", sb.pending.size()));

    $display("Hashed %0d messages from %0d bytes (%0d reserved commands ignored).",
             sb.messages, sb.bytes_absorbed, sb.ignored);
    $display("Checked %0d digest words over four idle and stall phases, %0d mismatches.",
             sb.words_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("custom_byte_stream_hash_tb OK");
    end else begin
      $display("custom_byte_stream_hash_tb NOT OK");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #5000000;
    $display("Run timed out.");
    $display("custom_byte_stream_hash_tb NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/cbsh_pkg.sv
design/cbsh_ctrl.sv
design/cbsh_datapath.sv
design/custom_byte_stream_hash.sv
design/cbsh_checker.sv
sim/custom_byte_stream_hash_tb.sv
